// ===== rtl/reflow_setpoint_profile_assert.svh =====
// Assertion macros shared by the reflow setpoint profile RTL.
`ifndef REFLOW_SETPOINT_PROFILE_ASSERT_SVH
`define REFLOW_SETPOINT_PROFILE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsp assertion failed");

// Next-cycle implication, checked out of reset.
`define RSP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsp assertion failed");

`endif

// ===== rtl/rsp_pkg.sv =====
// Types and constants of the reflow setpoint profile.
package rsp_pkg;

  localparam int unsigned TEMP_W  = 9;
  localparam int unsigned TIME_W  = 10;
  localparam int unsigned T_W     = 16;
  localparam int unsigned END_W   = 12;
  localparam int unsigned PROD_W  = TEMP_W + TIME_W;
  localparam int unsigned QUO_W   = 9;
  localparam int unsigned DIV_STAGES   = 3;
  localparam int unsigned BITS_PER_STG = QUO_W / DIV_STAGES;

  localparam int unsigned AMBIENT_DEGREES = 25;
  localparam int unsigned HOLD_END_TEMP   = 150;
  localparam int unsigned COOL_RATE       = 2;
  localparam int unsigned COOL_FLOOR      = 40;
  localparam int unsigned COOL_STEPS      = (HOLD_END_TEMP - COOL_FLOOR) / COOL_RATE;

  localparam logic [2:0] REG_BAKE      = 3'd0;
  localparam logic [2:0] REG_PRE_TIME  = 3'd1;
  localparam logic [2:0] REG_PRE_TEMP  = 3'd2;
  localparam logic [2:0] REG_SOAK_TIME = 3'd3;
  localparam logic [2:0] REG_SOAK_TEMP = 3'd4;
  localparam logic [2:0] REG_RAMP_TIME = 3'd5;
  localparam logic [2:0] REG_PEAK_TEMP = 3'd6;
  localparam logic [2:0] REG_HOLD_TIME = 3'd7;

  localparam logic [TEMP_W-1:0] RST_BAKE      = 9'd0;
  localparam logic [TIME_W-1:0] RST_PRE_TIME  = 10'd90;
  localparam logic [TEMP_W-1:0] RST_PRE_TEMP  = 9'd150;
  localparam logic [TIME_W-1:0] RST_SOAK_TIME = 10'd90;
  localparam logic [TEMP_W-1:0] RST_SOAK_TEMP = 9'd180;
  localparam logic [TIME_W-1:0] RST_RAMP_TIME = 10'd60;
  localparam logic [TEMP_W-1:0] RST_PEAK_TEMP = 9'd240;
  localparam logic [TIME_W-1:0] RST_HOLD_TIME = 10'd30;

  localparam logic [END_W-1:0] RST_E1 = END_W'(RST_PRE_TIME);
  localparam logic [END_W-1:0] RST_E2 = RST_E1 + END_W'(RST_SOAK_TIME);
  localparam logic [END_W-1:0] RST_E3 = RST_E2 + END_W'(RST_RAMP_TIME);
  localparam logic [END_W-1:0] RST_E4 = RST_E3 + END_W'(RST_HOLD_TIME);

  typedef enum logic [2:0] {
    STG_PREHEAT = 3'd0,
    STG_SOAK    = 3'd1,
    STG_RAMP    = 3'd2,
    STG_HOLD    = 3'd3,
    STG_COOL    = 3'd4
  } stage_t;

  typedef struct packed {
    logic [TEMP_W-1:0] bake;
    logic [TIME_W-1:0] pre_time;
    logic [TEMP_W-1:0] pre_temp;
    logic [TIME_W-1:0] soak_time;
    logic [TEMP_W-1:0] soak_temp;
    logic [TIME_W-1:0] ramp_time;
    logic [TEMP_W-1:0] peak_temp;
    logic [TIME_W-1:0] hold_time;
    logic [END_W-1:0]  e1;
    logic [END_W-1:0]  e2;
    logic [END_W-1:0]  e3;
    logic [END_W-1:0]  e4;
  } cfg_t;

  // Payload carried down the pipe; later stages fill rem and quo.
  typedef struct packed {
    stage_t            stage;
    logic              bypass;
    logic [TEMP_W-1:0] base;
    logic              neg;
    logic [TEMP_W-1:0] mag;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } pipe_t;

endpackage

// ===== rtl/rsp_cfg.sv =====
// APB register file holding the profile settings and the derived segment ends.
module rsp_cfg import rsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [TEMP_W-1:0] bake_r, pre_temp_r, soak_temp_r, peak_temp_r;
  logic [TIME_W-1:0] pre_time_r, soak_time_r, ramp_time_r, hold_time_r;
  logic [TIME_W-1:0] pre_time_nxt, soak_time_nxt, ramp_time_nxt, hold_time_nxt;
  logic [END_W-1:0]  e1_r, e2_r, e3_r, e4_r;
  logic [END_W-1:0]  e1_nxt, e2_nxt, e3_nxt, e4_nxt;
  logic [2:0]        idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bake_r      <= RST_BAKE;
      pre_time_r  <= RST_PRE_TIME;
      pre_temp_r  <= RST_PRE_TEMP;
      soak_time_r <= RST_SOAK_TIME;
      soak_temp_r <= RST_SOAK_TEMP;
      ramp_time_r <= RST_RAMP_TIME;
      peak_temp_r <= RST_PEAK_TEMP;
      hold_time_r <= RST_HOLD_TIME;
    end else if (wr_en) begin
      unique case (idx)
        REG_BAKE:      bake_r      <= pwdata[TEMP_W-1:0];
        REG_PRE_TIME:  pre_time_r  <= pwdata[TIME_W-1:0];
        REG_PRE_TEMP:  pre_temp_r  <= pwdata[TEMP_W-1:0];
        REG_SOAK_TIME: soak_time_r <= pwdata[TIME_W-1:0];
        REG_SOAK_TEMP: soak_temp_r <= pwdata[TEMP_W-1:0];
        REG_RAMP_TIME: ramp_time_r <= pwdata[TIME_W-1:0];
        REG_PEAK_TEMP: peak_temp_r <= pwdata[TEMP_W-1:0];
        REG_HOLD_TIME: hold_time_r <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment ends load at the same edge as the time register being written.
  always_comb begin
    pre_time_nxt  = pre_time_r;
    soak_time_nxt = soak_time_r;
    ramp_time_nxt = ramp_time_r;
    hold_time_nxt = hold_time_r;
    if (wr_en) begin
      unique case (idx)
        REG_PRE_TIME:  pre_time_nxt  = pwdata[TIME_W-1:0];
        REG_SOAK_TIME: soak_time_nxt = pwdata[TIME_W-1:0];
        REG_RAMP_TIME: ramp_time_nxt = pwdata[TIME_W-1:0];
        REG_HOLD_TIME: hold_time_nxt = pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
    e1_nxt = END_W'(pre_time_nxt);
    e2_nxt = e1_nxt + END_W'(soak_time_nxt);
    e3_nxt = e2_nxt + END_W'(ramp_time_nxt);
    e4_nxt = e3_nxt + END_W'(hold_time_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r <= RST_E1;
      e2_r <= RST_E2;
      e3_r <= RST_E3;
      e4_r <= RST_E4;
    end else begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      e3_r <= e3_nxt;
      e4_r <= e4_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BAKE:      prdata = 32'(bake_r);
      REG_PRE_TIME:  prdata = 32'(pre_time_r);
      REG_PRE_TEMP:  prdata = 32'(pre_temp_r);
      REG_SOAK_TIME: prdata = 32'(soak_time_r);
      REG_SOAK_TEMP: prdata = 32'(soak_temp_r);
      REG_RAMP_TIME: prdata = 32'(ramp_time_r);
      REG_PEAK_TEMP: prdata = 32'(peak_temp_r);
      REG_HOLD_TIME: prdata = 32'(hold_time_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.bake      = bake_r;
    cfg.pre_time  = pre_time_r;
    cfg.pre_temp  = pre_temp_r;
    cfg.soak_time = soak_time_r;
    cfg.soak_temp = soak_temp_r;
    cfg.ramp_time = ramp_time_r;
    cfg.peak_temp = peak_temp_r;
    cfg.hold_time = hold_time_r;
    cfg.e1        = e1_r;
    cfg.e2        = e2_r;
    cfg.e3        = e3_r;
    cfg.e4        = e4_r;
  end

endmodule

// ===== rtl/rsp_seg.sv =====
// Segment select stage: picks endpoints, offset and span for one time value.
module rsp_seg import rsp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           in_valid,
  input  logic [T_W-1:0] in_t,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output pipe_t          out_pipe
);

  logic              valid_r;
  pipe_t             pipe_r;
  pipe_t             pipe_nxt;
  logic [TEMP_W-1:0] finish;
  logic [END_W-1:0]  t12;
  logic [END_W-1:0]  off;
  logic [T_W-1:0]    cool_d;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_pipe  = pipe_r;
  assign t12       = in_t[END_W-1:0];
  assign cool_d    = in_t - T_W'(cfg.e4);

  always_comb begin
    pipe_nxt        = '0;
    pipe_nxt.den    = TIME_W'(1);
    finish          = '0;
    off             = '0;
    priority if (cfg.bake != '0) begin
      pipe_nxt.stage  = STG_SOAK;
      pipe_nxt.bypass = 1'b1;
      pipe_nxt.base   = cfg.bake;
    end else if (in_t <= T_W'(cfg.e1)) begin
      pipe_nxt.stage = STG_PREHEAT;
      pipe_nxt.base  = TEMP_W'(AMBIENT_DEGREES);
      finish         = cfg.pre_temp;
      pipe_nxt.num   = in_t[TIME_W-1:0];
      // zero-length preheat only meets t = 0; 0/1 keeps the start value
      pipe_nxt.den   = (cfg.pre_time == '0) ? TIME_W'(1) : cfg.pre_time;
    end else if (in_t <= T_W'(cfg.e2)) begin
      pipe_nxt.stage = STG_SOAK;
      pipe_nxt.base  = cfg.pre_temp;
      finish         = cfg.soak_temp;
      off            = t12 - cfg.e1;
      pipe_nxt.num   = off[TIME_W-1:0];
      pipe_nxt.den   = cfg.soak_time;
    end else if (in_t <= T_W'(cfg.e3)) begin
      pipe_nxt.stage = STG_RAMP;
      pipe_nxt.base  = cfg.soak_temp;
      finish         = cfg.peak_temp;
      off            = t12 - cfg.e2;
      pipe_nxt.num   = off[TIME_W-1:0];
      pipe_nxt.den   = cfg.ramp_time;
    end else if (in_t <= T_W'(cfg.e4)) begin
      pipe_nxt.stage = STG_HOLD;
      pipe_nxt.base  = cfg.peak_temp;
      finish         = TEMP_W'(HOLD_END_TEMP);
      off            = t12 - cfg.e3;
      pipe_nxt.num   = off[TIME_W-1:0];
      pipe_nxt.den   = cfg.hold_time;
    end else begin
      pipe_nxt.stage  = STG_COOL;
      pipe_nxt.bypass = 1'b1;
      if (cool_d > T_W'(COOL_STEPS)) begin
        pipe_nxt.base = TEMP_W'(COOL_FLOOR);
      end else begin
        pipe_nxt.base = TEMP_W'(HOLD_END_TEMP) - TEMP_W'(cool_d[6:0] * COOL_RATE);
      end
    end
    if (!pipe_nxt.bypass) begin
      pipe_nxt.neg = finish < pipe_nxt.base;
      pipe_nxt.mag = pipe_nxt.neg ? (pipe_nxt.base - finish) : (finish - pipe_nxt.base);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pipe_r <= pipe_nxt;
    end
  end

endmodule

// ===== rtl/rsp_div.sv =====
// Pipelined restoring divider, a few quotient bits per register stage.
module rsp_div import rsp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  pipe_t in_pipe,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output pipe_t out_pipe
);

  logic [DIV_STAGES-1:0] valid_r;
  logic [DIV_STAGES:0]   rdy;
  pipe_t                 stg_r   [DIV_STAGES];
  pipe_t                 stg_nxt [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];
  assign out_valid       = valid_r[DIV_STAGES-1];
  assign out_pipe        = stg_r[DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    pipe_t src;
    logic  src_valid;

    if (k == 0) begin : g_first
      assign src       = in_pipe;
      assign src_valid = in_valid;
    end else begin : g_rest
      assign src       = stg_r[k-1];
      assign src_valid = valid_r[k-1];
    end

    assign rdy[k] = !valid_r[k] || rdy[k+1];

    // quotient bits from the top down, BITS_PER_STG of them here
    always_comb begin
      pipe_t             p;
      logic [PROD_W-1:0] sh;
      int                b;
      p = src;
      for (int j = 0; j < BITS_PER_STG; j++) begin
        b  = QUO_W - 1 - k * BITS_PER_STG - j;
        sh = PROD_W'(p.den) << b;
        if (p.rem >= sh) begin
          p.rem    = p.rem - sh;
          p.quo[b] = 1'b1;
        end
      end
      stg_nxt[k] = p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_valid) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

endmodule

// ===== rtl/reflow_setpoint_profile.sv =====
// Reflow setpoint profile: elapsed seconds in, target temperature and stage out.
//
// Input stream: in_tdata[15:0] carries elapsed seconds; one item per accepted
// transfer, and a new item may be accepted in every cycle while in_tready is high.
// Output stream: out_tdata[8:0] is the target temperature in degrees,
// out_tuser[2:0] the stage (preheat, soak, ramp, hold, cooldown).
// Each item gives exactly one result, in order. Each item passes six register
// stages (segment select, multiply, three divider stages of three quotient
// bits each, output register), the first loaded at the accepting edge.
// Sustained throughput is one item per cycle while out_tready stays high.
// A stall on out_tready holds the output register; each stage keeps its item
// until the next one frees, so bubbles close up and in_tready drops only once
// all six stages are full.
// Settings sit on the APB port (one register per word, pready always high);
// write them only while no item is in flight. Segment ends load at the same
// edge as the write. Synchronous reset empties the pipe and loads default
// settings (reflow mode, 90/150, 90/180, 60/240, 30 s hold).
`include "reflow_setpoint_profile_assert.svh"

module reflow_setpoint_profile import rsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] elapsed_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [8:0] target_temp, [15:9] zero
  output logic [2:0]  out_tuser,   // [2:0] stage
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t              cfg;
  logic              seg_valid, seg_ready;
  pipe_t             seg_pipe;
  logic              mul_valid_r, mul_ready;
  pipe_t             mul_r, mul_nxt;
  logic              div_valid, div_ready;
  pipe_t             div_pipe;
  logic              fin_ready;
  logic              out_valid_r;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  stage_t            stage_r;

  rsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rsp_seg u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_t      (in_tdata),
    .in_ready  (in_tready),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_pipe  (seg_pipe)
  );

  // multiply stage: span times offset becomes the dividend
  assign mul_ready = !mul_valid_r || div_ready;
  assign seg_ready = mul_ready;

  always_comb begin
    mul_nxt     = seg_pipe;
    mul_nxt.rem = PROD_W'(seg_pipe.mag) * PROD_W'(seg_pipe.num);
    mul_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_r <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && seg_valid) begin
      mul_r <= mul_nxt;
    end
  end

  rsp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid_r),
    .in_pipe   (mul_r),
    .in_ready  (div_ready),
    .out_valid (div_valid),
    .out_ready (fin_ready),
    .out_pipe  (div_pipe)
  );

  // output register: start value plus or minus the quotient, or the bare start value on bypass
  assign fin_ready = !out_valid_r || out_tready;

  always_comb begin
    priority if (div_pipe.bypass) begin
      temp_nxt = div_pipe.base;
    end else if (div_pipe.neg) begin
      temp_nxt = div_pipe.base - TEMP_W'(div_pipe.quo);
    end else begin
      temp_nxt = div_pipe.base + TEMP_W'(div_pipe.quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && div_valid) begin
      temp_r  <= temp_nxt;
      stage_r <= div_pipe.stage;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(temp_r);
  assign out_tuser  = stage_r;

  `RSP_ASSERT_IMPL(a_seg_num_in_span, seg_valid && !seg_pipe.bypass,
    seg_pipe.num <= seg_pipe.den && seg_pipe.den != '0)
  `RSP_ASSERT_IMPL(a_quo_within_span, div_valid && !div_pipe.bypass,
    div_pipe.quo <= div_pipe.mag && div_pipe.rem < PROD_W'(div_pipe.den))
  `RSP_ASSERT_IMPL(a_cool_floor, out_tvalid && out_tuser == STG_COOL,
    out_tdata[8:0] >= 9'(COOL_FLOOR) && out_tdata[8:0] <= 9'(HOLD_END_TEMP))
  `RSP_ASSERT_NEXT(a_div_holds_on_stall, div_valid && !fin_ready,
    div_valid && $stable(div_pipe))

endmodule
